>>> rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  // Radix register limits and reset value.
  localparam logic [5:0] RADIX_RESET   = 6'd10;
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;
  localparam logic [5:0] RADIX_DECIMAL = 6'd10;

  // Character codes.
  localparam logic [6:0] CH_ZERO   = 7'h30;
  localparam logic [6:0] CH_LETTER = 7'h41;
  localparam logic [6:0] CH_MINUS  = 7'h2D;
  localparam logic [5:0] MAX_DECIMAL_DIGIT = 6'd9;

  // Classification of one item, passed from the front to the back.
  typedef struct packed {
    logic       neg;
    logic [5:0] radix;
  } item_ctl_t;

  localparam int CTL_BITS = $bits(item_ctl_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_PREP,
    ST_EMIT
  } back_state_t;

  // Clamps the register to the supported range of bases.
  function automatic logic [5:0] sat_radix(input logic [5:0] r);
    logic [5:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Maps a digit value to its ASCII character.
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [5:0] off;
    off = d - 6'd10;
    if (d > MAX_DECIMAL_DIGIT) begin
      return {1'b0, off} + CH_LETTER;
    end
    return {1'b0, d} + CH_ZERO;
  endfunction

endpackage

>>> rtl/itoa_front.sv
`timescale 1ns / 1ps

module itoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  q_full,
  output logic                  q_wr,
  output itoa_pkg::item_ctl_t   q_ctl,
  output logic [VALUE_BITS-1:0] q_mag
);

  logic [5:0] radix;
  logic [5:0] eff_radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // Only decimal carries a sign; every other base sees the raw bit pattern.
  always_comb begin
    eff_radix   = itoa_pkg::sat_radix(radix);
    q_ctl.radix = eff_radix;
    q_ctl.neg   = (eff_radix == itoa_pkg::RADIX_DECIMAL) && value[VALUE_BITS-1];
    q_mag       = q_ctl.neg ? (~value + VALUE_BITS'(1)) : value;
    q_wr        = push && !q_full;
  end

endmodule

>>> rtl/itoa_queue.sv
`timescale 1ns / 1ps

module itoa_queue #(
  parameter int DATA_BITS = 39
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 full,
  input  logic                 rd,
  output logic [DATA_BITS-1:0] rd_data,
  output logic                 empty
);

  logic [DATA_BITS-1:0] slots [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/itoa_back.sv
`timescale 1ns / 1ps

module itoa_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  itoa_pkg::item_ctl_t   q_ctl,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output logic [6:0]            character,
  output logic                  last
);

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  itoa_pkg::back_state_t state, state_next;
  itoa_pkg::item_ctl_t   ctl;

  logic [VALUE_BITS-1:0] dvd;
  logic [5:0]            rem;
  logic [BIT_W-1:0]      bcnt;
  logic [CNT_W-1:0]      cnt;
  logic [6:0]            stack [VALUE_BITS];
  logic [6:0]            rd_char;
  logic [IDX_W-1:0]      rd_idx;

  logic                  out_valid;
  logic                  out_free;

  logic [6:0]            rem_sh;
  logic                  fits;
  logic [5:0]            rem_new;
  logic [VALUE_BITS-1:0] dvd_new;
  logic                  bit_end;
  logic                  quo_zero;

  logic                  take;
  logic                  step;
  logic                  load_out;
  logic                  emit_digit;
  logic [6:0]            out_char_next;
  logic                  out_last_next;

  // One restoring division step: shift in the next dividend bit and subtract the radix.
  always_comb begin
    rem_sh   = {rem, dvd[VALUE_BITS-1]};
    fits     = (rem_sh >= {1'b0, ctl.radix});
    rem_new  = fits ? 6'(rem_sh - {1'b0, ctl.radix}) : rem_sh[5:0];
    dvd_new  = {dvd[VALUE_BITS-2:0], fits};
    bit_end  = (bcnt == BIT_W'(VALUE_BITS - 1));
    quo_zero = (dvd_new == '0);
    out_free = !out_valid || pop;
    rd_idx   = IDX_W'(cnt - CNT_W'(1));
  end

  always_comb begin
    state_next    = state;
    take          = 1'b0;
    step          = 1'b0;
    load_out      = 1'b0;
    emit_digit    = 1'b0;
    out_char_next = character;
    out_last_next = 1'b0;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (!q_empty) begin
          take       = 1'b1;
          state_next = itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_DIV: begin
        step = 1'b1;
        if (bit_end && quo_zero) begin
          state_next = ctl.neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_PREP;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_char_next = itoa_pkg::CH_MINUS;
          state_next    = itoa_pkg::ST_PREP;
        end
      end
      itoa_pkg::ST_PREP: begin
        state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out      = 1'b1;
          emit_digit    = 1'b1;
          out_char_next = rd_char;
          out_last_next = (cnt == CNT_W'(1));
          state_next    = out_last_next ? itoa_pkg::ST_IDLE : itoa_pkg::ST_PREP;
        end
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  assign q_rd  = take;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        cnt <= '0;
      end else if (step && bit_end) begin
        cnt <= cnt + CNT_W'(1);
      end else if (emit_digit) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl  <= q_ctl;
      dvd  <= q_mag;
      rem  <= '0;
      bcnt <= '0;
    end else if (step) begin
      dvd <= dvd_new;
      if (bit_end) begin
        rem  <= '0;
        bcnt <= '0;
      end else begin
        rem  <= rem_new;
        bcnt <= bcnt + BIT_W'(1);
      end
    end
    if (load_out) begin
      character <= out_char_next;
      last      <= out_last_next;
    end
  end

  // Digit stack: written least significant first, read back in reverse.
  always_ff @(posedge clk) begin
    if (step && bit_end) begin
      stack[cnt[IDX_W-1:0]] <= itoa_pkg::digit_char(rem_new);
    end
    rd_char <= stack[rd_idx];
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(VALUE_BITS))
    else $error("digit count exceeds the stack depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_EMIT) |-> (cnt != '0))
    else $error("emitting with an empty digit stack");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == itoa_pkg::ST_DIV) |-> ({1'b0, rem} < {1'b0, ctl.radix}))
    else $error("partial remainder not below the radix");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (state != itoa_pkg::ST_IDLE) |->
      (ctl.radix >= itoa_pkg::RADIX_MIN && ctl.radix <= itoa_pkg::RADIX_MAX))
    else $error("radix out of range during conversion");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_last_next) |=> (state == itoa_pkg::ST_IDLE))
    else $error("final character issued but conversion still running");
`endif

endmodule

>>> rtl/integer_to_radix_ascii_core.sv
`timescale 1ns / 1ps

// Integer to ASCII converter in a base from 2 to 36.
// Input channel: drive value and raise push; the item is taken at a clock edge where full is low.
// Result channel: while empty is low, character and last show the oldest waiting character;
// raise pop to take it. Characters come most significant digit first, with '-' ahead of a
// negative decimal value, and last marks the final character of each value's string.
// The user must set the base through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce this. Codes below 2 act as 2 and codes above 36 act as 36.
// In any base but ten the value is its raw bit pattern. Each digit takes a full pass of the
// shared bit-serial divider over all VALUE_BITS dividend bits, and each character then
// leaves the digit stack through the ST_PREP and ST_EMIT states.
// A two-entry queue sits between input classification and the converter, so up to two
// further items are accepted while one is converting, and the output register lets the
// converter finish a character while the previous one still waits.
// When the receiver stalls, the converter holds its next character and nothing is lost.
// Reset empties the queue and the output, aborts any conversion and sets the base to ten.
module integer_to_radix_ascii_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [5:0]            cfg_wr_data,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  empty,
  input  logic                  pop,
  output logic [6:0]            character,
  output logic                  last
);

  localparam int Q_BITS = itoa_pkg::CTL_BITS + VALUE_BITS;

  // Classified item written by the front into the queue.
  logic                  q_wr;
  itoa_pkg::item_ctl_t   wr_ctl;
  logic [VALUE_BITS-1:0] wr_mag;

  // Queue head as seen by the converter.
  logic                  q_rd;
  logic                  q_empty;
  logic [Q_BITS-1:0]     q_head;
  itoa_pkg::item_ctl_t   rd_ctl;
  logic [VALUE_BITS-1:0] rd_mag;

  assign rd_ctl = q_head[Q_BITS-1:VALUE_BITS];
  assign rd_mag = q_head[VALUE_BITS-1:0];

  itoa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .value      (value),
    .q_full     (full),
    .q_wr       (q_wr),
    .q_ctl      (wr_ctl),
    .q_mag      (wr_mag)
  );

  itoa_queue #(
    .DATA_BITS(Q_BITS)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data({wr_ctl, wr_mag}),
    .full   (full),
    .rd     (q_rd),
    .rd_data(q_head),
    .empty  (q_empty)
  );

  itoa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_ctl    (rd_ctl),
    .q_mag    (rd_mag),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .character(character),
    .last     (last)
  );

endmodule
